// ===== rtl/rtti_pkg.sv =====
// ----------------------------------------------------------------------------
// rtti_pkg
// shared types and constants for the radix text to integer unit
// ----------------------------------------------------------------------------
package rtti_pkg;

    localparam int CODE_W   = 16;
    localparam int VALUE_W  = 64;
    localparam int RADIX_W  = 6;
    localparam int WSEL_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = RADIX_W;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIX              = 3'd0,
        REG_ALLOW_PLUS         = 3'd1,
        REG_ALLOW_LEADING_ZERO = 3'd2,
        REG_SIGNED_MODE        = 3'd3,
        REG_VALUE_WIDTH        = 3'd4
    } reg_idx_t;

    // result width selector codes
    localparam logic [WSEL_W-1:0] WSEL_8  = 2'd0;
    localparam logic [WSEL_W-1:0] WSEL_16 = 2'd1;
    localparam logic [WSEL_W-1:0] WSEL_32 = 2'd2;
    localparam logic [WSEL_W-1:0] WSEL_64 = 2'd3;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic               allow_plus;
        logic               allow_leading_zero;
        logic               signed_mode;
        logic [WSEL_W-1:0]  value_width;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        radix:              6'd10,
        allow_plus:         1'b0,
        allow_leading_zero: 1'b0,
        signed_mode:        1'b0,
        value_width:        WSEL_64
    };

    // per-string parse state
    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic               at_start;
        logic               at_first_digit;
        logic               zero_led;
        logic               negative;
        logic               failed;
        logic               digit_seen;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        acc:            '0,
        at_start:       1'b1,
        at_first_digit: 1'b0,
        zero_led:       1'b0,
        negative:       1'b0,
        failed:         1'b0,
        digit_seen:     1'b0
    };

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] value;
    } result_t;

endpackage

// ===== rtl/rtti_cfg.sv =====
// ----------------------------------------------------------------------------
// rtti_cfg
// configuration register file, written by index, no read-back
// ----------------------------------------------------------------------------
module rtti_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rtti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rtti_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rtti_pkg::cfg_t                   cfg
);
    import rtti_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIX:              cfg_next.radix = cfg_data;
                REG_ALLOW_PLUS:         cfg_next.allow_plus = cfg_data[0];
                REG_ALLOW_LEADING_ZERO: cfg_next.allow_leading_zero = cfg_data[0];
                REG_SIGNED_MODE:        cfg_next.signed_mode = cfg_data[0];
                REG_VALUE_WIDTH:        cfg_next.value_width = cfg_data[WSEL_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/rtti_step.sv =====
// ----------------------------------------------------------------------------
// rtti_step
// one character of parsing: digit decode, multiply-add, range check, result
// ----------------------------------------------------------------------------
module rtti_step (
    input  rtti_pkg::parse_state_t            st,
    input  logic [rtti_pkg::CODE_W-1:0]       code_unit,
    input  logic                              last,
    input  rtti_pkg::cfg_t                    cfg,
    output rtti_pkg::parse_state_t            st_next,
    output rtti_pkg::result_t                 res
);
    import rtti_pkg::*;

    localparam logic [CODE_W-1:0] CH_PLUS  = 16'h002B;
    localparam logic [CODE_W-1:0] CH_MINUS = 16'h002D;
    localparam logic [CODE_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CODE_W-1:0] CH_NINE  = 16'h0039;
    localparam logic [CODE_W-1:0] CH_LA    = 16'h0061;
    localparam logic [CODE_W-1:0] CH_LZ    = 16'h007A;
    localparam logic [CODE_W-1:0] CH_UA    = 16'h0041;
    localparam logic [CODE_W-1:0] CH_UZ    = 16'h005A;
    localparam int PROD_W = VALUE_W + RADIX_W + 1;

    logic               is_digit;
    logic [RADIX_W-1:0] digit;
    logic               first;
    logic [VALUE_W-1:0] lim;
    logic [VALUE_W-1:0] umask;
    logic [PROD_W-1:0]  prod;
    parse_state_t       st_upd;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] v;

    // digit decode: 0-9, a-z, A-Z
    always_comb
    begin
        is_digit = 1'b1;
        digit    = '0;
        if (code_unit >= CH_ZERO && code_unit <= CH_NINE)
            digit = RADIX_W'(code_unit - CH_ZERO);
        else if (code_unit >= CH_LA && code_unit <= CH_LZ)
            digit = RADIX_W'(code_unit - CH_LA + 16'd10);
        else if (code_unit >= CH_UA && code_unit <= CH_UZ)
            digit = RADIX_W'(code_unit - CH_UA + 16'd10);
        else
            is_digit = 1'b0;
    end

    // width mask and magnitude limit
    always_comb
    begin
        unique case (cfg.value_width)
            WSEL_8:  umask = {{(VALUE_W-8){1'b0}},  {8{1'b1}}};
            WSEL_16: umask = {{(VALUE_W-16){1'b0}}, {16{1'b1}}};
            WSEL_32: umask = {{(VALUE_W-32){1'b0}}, {32{1'b1}}};
            default: umask = {VALUE_W{1'b1}};
        endcase
        if (!cfg.signed_mode)
            lim = umask;
        else if (st.negative)
            lim = (umask >> 1) + VALUE_W'(1);
        else
            lim = umask >> 1;
    end

    // acc * radix + digit at full width, compared against the limit directly
    assign prod  = PROD_W'(st.acc) * cfg.radix + PROD_W'(digit);
    assign first = st.at_start | st.at_first_digit;

    always_comb
    begin
        st_upd = st;
        if (!st.failed)
        begin
            priority if (st.at_start && code_unit == CH_PLUS)
            begin
                if (!cfg.allow_plus)
                    st_upd.failed = 1'b1;
                else
                begin
                    st_upd.at_start       = 1'b0;
                    st_upd.at_first_digit = 1'b1;
                    st_upd.failed         = last;
                end
            end
            else if (st.at_start && code_unit == CH_MINUS && cfg.signed_mode)
            begin
                st_upd.negative       = 1'b1;
                st_upd.at_start       = 1'b0;
                st_upd.at_first_digit = 1'b1;
                st_upd.failed         = last;
            end
            else if (!first && st.zero_led && !cfg.allow_leading_zero)
                st_upd.failed = 1'b1;
            else if (!is_digit || digit >= cfg.radix)
                st_upd.failed = 1'b1;
            else if (prod > PROD_W'(lim))
                st_upd.failed = 1'b1;
            else
            begin
                st_upd.acc = prod[VALUE_W-1:0];
                if (first)
                    st_upd.zero_led = (code_unit == CH_ZERO);
                st_upd.at_start       = 1'b0;
                st_upd.at_first_digit = 1'b0;
                st_upd.digit_seen     = 1'b1;
            end
        end
    end

    // result formatting on the last character
    always_comb
    begin
        mag = st_upd.negative ? (VALUE_W'(0) - st_upd.acc) : st_upd.acc;
        v   = mag & umask;
        if (cfg.signed_mode)
        begin
            unique case (cfg.value_width)
                WSEL_8:  v = {{(VALUE_W-8){mag[7]}},   mag[7:0]};
                WSEL_16: v = {{(VALUE_W-16){mag[15]}}, mag[15:0]};
                WSEL_32: v = {{(VALUE_W-32){mag[31]}}, mag[31:0]};
                default: v = mag;
            endcase
        end
        res.ok    = !st_upd.failed && st_upd.digit_seen;
        res.value = res.ok ? v : '0;
    end

    assign st_next = last ? STATE_RESET : st_upd;

endmodule

// ===== rtl/radix_text_to_integer_unit.sv =====
// ----------------------------------------------------------------------------
// radix_text_to_integer_unit
// streams text characters in, gives one parsed integer per string
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata = code_unit, s_tlast = last
//  m_*       out  m_tvalid/m_tready  m_tdata = value, m_tuser = ok
//  cfg_*     in   cfg_we             cfg_index, cfg_data (no read-back)
//
// one item per cycle sustained unless a last character waits on a stalled
// result: an input register holds the character, the parse step (64x6
// multiply-add and range compare) runs between it and the parse-state and
// result registers, and a result is registered as its last character leaves
// a non-last character never waits on the output; a last character waits
// in the input register only while a previous result is still stalled
// reset puts the configuration at its defaults and the parser at string start
// ----------------------------------------------------------------------------
module radix_text_to_integer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rtti_pkg::CODE_W-1:0]      s_tdata,   // [15:0] code_unit
    input  logic                             s_tlast,
    // master side
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rtti_pkg::VALUE_W-1:0]     m_tdata,   // [63:0] value
    output logic [0:0]                       m_tuser,   // [0] ok
    // configuration
    input  logic                             cfg_we,
    input  logic [rtti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rtti_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rtti_pkg::*;

    cfg_t               cfg;

    // input register
    logic               in_v_reg;
    logic               in_v_next;
    logic [CODE_W-1:0]  in_code_reg;
    logic               in_last_reg;

    // parse state
    parse_state_t       st_reg;
    parse_state_t       st_step;

    // result register
    logic               out_v_reg;
    logic               out_v_next;
    result_t            out_reg;
    result_t            res_step;

    logic               adv;
    logic               s_take;

    rtti_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtti_step u_step (
        .st        (st_reg),
        .code_unit (in_code_reg),
        .last      (in_last_reg),
        .cfg       (cfg),
        .st_next   (st_step),
        .res       (res_step)
    );

    // the held character moves on unless it ends a string and the result
    // register is still waiting on the consumer
    assign adv      = in_v_reg && (!in_last_reg || !out_v_reg || m_tready);
    assign s_tready = !in_v_reg || adv;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (s_take)
            in_v_next = 1'b1;
        else if (adv)
            in_v_next = 1'b0;

        out_v_next = out_v_reg;
        if (adv && in_last_reg)
            out_v_next = 1'b1;
        else if (m_tready)
            out_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            st_reg    <= STATE_RESET;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
            if (adv)
                st_reg <= st_step;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_code_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (adv && in_last_reg)
            out_reg <= res_step;
    end

    assign m_tvalid   = out_v_reg;
    assign m_tdata    = out_reg.value;
    assign m_tuser[0] = out_reg.ok;

    // a failed string yields a zero value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("failed result carries a nonzero value");

    // the parser is back at string start after each last character
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_last_reg |=> st_reg.at_start && !st_reg.failed && !st_reg.digit_seen)
        else $error("parse state not cleared after end of string");

    // once failed, a string stays failed until its end
    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.failed && adv && !in_last_reg |=> st_reg.failed)
        else $error("failure flag dropped mid-string");

    // unsigned 8-bit results fit in the low byte
    a_u8_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && !cfg.signed_mode && cfg.value_width == WSEL_8
        |-> m_tdata[VALUE_W-1:8] == '0)
        else $error("unsigned 8-bit result out of range");

    // input stall only when the input register is occupied
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_v_reg && in_last_reg && out_v_reg && !m_tready)
        else $error("input stalled without a pending result");

endmodule
